>>> rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, request and status codes and control state type for the
// bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int REQ_W      = 2;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CAP_W      = 5;
  // front, back, count, empty, full = 71 bits, padded to 9 bytes
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 * VALUE_W + COUNT_W + 2);

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage

>>> rtl/bdq_mem.sv
// ----------------------------------------------------------------------------
// bdq_mem
// Slot storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bdq_mem #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32,
  parameter int AW        = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr_a,
  input  logic [AW-1:0]        raddr_b,
  output logic [WORD_BITS-1:0] rdata_a,
  output logic [WORD_BITS-1:0] rdata_b
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/bounded_deque_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_unit
// Double-ended queue of words in a ring buffer with head and tail pointers.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                 | tuser
//  --------+-----+---------------------------------------+-------------
//  in_     | in  | push_value[31:0]                      | req_type
//  out_    | out | front, back, count, empty, full, pad  | status
//  cfg_    | in  | capacity[4:0] (cfg_wdata, cfg_we)     | -
//
//  Each request passes through accept (pointer update and slot write),
//  read (both ends fetched from the slot memory) and load (result register).
//  The registered read data of the two-port slot memory calls for the read step.
//  A result stalled at out_ holds the block in the load step; the next
//  request is taken as soon as the result register is loaded.
//  Reset empties the deque (head 0, tail head - 1, count 0) and sets capacity to 16; slots are not cleared.
//
module bounded_deque_unit #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bdq_pkg::VALUE_W-1:0]     in_tdata,   // push_value[31:0]
  input  logic [bdq_pkg::REQ_W-1:0]       in_tuser,   // req_type[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // front_value[31:0], back_value[63:32], entry_count[68:64],
  // is_empty[69], is_full[70], zero[71]
  output logic [bdq_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [bdq_pkg::STATUS_W-1:0]    out_tuser,  // status[1:0]
  input  logic                            cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]       cfg_wdata
);

  import bdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - 1'b1;
  endfunction

  // pointer state; tail_r is the back slot, head - 1 when empty
  logic [AW-1:0]  head_r, head_nxt;
  logic [AW-1:0]  tail_r, tail_nxt;
  logic [OW-1:0]  occ_r, occ_nxt;
  logic [CAP_W-1:0] cap_r;
  status_t        status_r, status_nxt;
  state_t         state_r, state_nxt;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [STATUS_W-1:0]   out_tuser_r;
  logic                  load_out;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] rd_front, rd_back;

  logic [CW-1:0]      eff_cap, occ_ext;
  logic               at_cap, is_zero;
  logic [VALUE_W-1:0] front_val, back_val;

  // capacity above the depth acts as the depth
  assign eff_cap = (CW'(cap_r) > DEPTH_C) ? DEPTH_C : CW'(cap_r);
  assign occ_ext = CW'(occ_r);
  assign at_cap  = (occ_ext >= eff_cap);
  assign is_zero = (occ_r == '0);

  assign mem_wdata = WORD_BITS'(in_tdata);

  bdq_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (head_r),
    .raddr_b (tail_r),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      tail_r   <= LAST_IDX;
      occ_r    <= '0;
      status_r <= STAT_DONE;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      occ_r    <= occ_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    in_tready  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = head_r;
    mem_re     = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt  = ST_READ;
          status_nxt = STAT_DONE;
          case (req_t'(in_tuser))
            REQ_PUSH_FRONT: begin
              if (at_cap) begin
                status_nxt = STAT_OVERFLOW;
              end else begin
                head_nxt  = idx_dec(head_r);
                mem_we    = 1'b1;
                mem_waddr = idx_dec(head_r);
                occ_nxt   = occ_r + 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              if (at_cap) begin
                status_nxt = STAT_OVERFLOW;
              end else begin
                tail_nxt  = idx_inc(tail_r);
                mem_we    = 1'b1;
                mem_waddr = idx_inc(tail_r);
                occ_nxt   = occ_r + 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              if (is_zero) begin
                status_nxt = STAT_UNDERFLOW;
              end else begin
                head_nxt = idx_inc(head_r);
                occ_nxt  = occ_r - 1'b1;
              end
            end
            REQ_POP_BACK: begin
              if (is_zero) begin
                status_nxt = STAT_UNDERFLOW;
              end else begin
                tail_nxt = idx_dec(tail_r);
                occ_nxt  = occ_r - 1'b1;
              end
            end
            default: begin
              status_nxt = STAT_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        // pointers are settled and any write has landed
        mem_re    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // empty queue reports all ones at both ends
  assign front_val = is_zero ? '1 : VALUE_W'(rd_front);
  assign back_val  = is_zero ? '1 : VALUE_W'(rd_back);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, at_cap, is_zero, occ_ext[COUNT_W-1:0],
                      back_val, front_val};
      out_tuser_r <= status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bounded_deque_unit. Requests go in on the in_
// stream, and an internal deque predictor works out the status, end words,
// count and flags for each accepted transfer. The results are then matched
// in order against every transfer taken off the out_ stream. Directed
// checks cover the value extremes, underflow, overflow and odd capacity
// settings. Random push/pop traffic then runs under several idle and
// stall mixes and capacities.
// ----------------------------------------------------------------------------
module tb_top;
  import bdq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int SETTLE     = 8;     // margin after the last result
  localparam int IDLE_LIMIT = 2000;  // cycles without any transfer
  localparam int MAX_REPORT = 10;

  // What the deque looks like after one request.
  typedef struct {
    req_t               req;
    status_t            status;
    logic [VALUE_W-1:0] front;
    logic [VALUE_W-1:0] back;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
  } deque_view_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata   = '0;
  logic [REQ_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata  = '0;

  // Predictor state: its own copy of the ring buffer and the capacity.
  logic [VALUE_W-1:0] slot_mem [DEPTH];
  logic [PTR_W-1:0]   head_ptr = '0;
  logic [COUNT_W-1:0] fill     = '0;
  logic [CAP_W-1:0]   cap_reg  = CAP_RESET;

  deque_view_t pending_views[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  always #1 clk = ~clk;

  bounded_deque_unit #(
    .DEPTH     (DEPTH),
    .WORD_BITS (VALUE_W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor: applies one request to the local deque copy and returns the
  // view the block must report for it. Refused requests leave state alone.
  // --------------------------------------------------------------------------
  function automatic deque_view_t deque_apply(req_t req, logic [VALUE_W-1:0] word);
    deque_view_t      v;
    logic [CAP_W-1:0] lim;
    logic [PTR_W-1:0] tail;
    // capacity beyond the storage depth behaves as the depth
    lim      = (cap_reg > DEPTH) ? CAP_W'(DEPTH) : cap_reg;
    v.req    = req;
    v.status = STAT_DONE;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill >= lim) begin
          v.status = STAT_OVERFLOW;
        end else if (req == REQ_PUSH_FRONT) begin
          head_ptr           = head_ptr - 1'b1;
          slot_mem[head_ptr] = word;
          fill               = fill + 1'b1;
        end else begin
          fill           = fill + 1'b1;
          tail           = head_ptr + fill[PTR_W-1:0] - 1'b1;
          slot_mem[tail] = word;
        end
      end
      default: begin
        if (fill == 0) begin
          v.status = STAT_UNDERFLOW;
        end else if (req == REQ_POP_FRONT) begin
          head_ptr = head_ptr + 1'b1;
          fill     = fill - 1'b1;
        end else begin
          fill = fill - 1'b1;
        end
      end
    endcase
    // tail index wraps in PTR_W bits; a full deque gives fill[PTR_W-1:0] == 0
    tail = head_ptr + fill[PTR_W-1:0] - 1'b1;
    if (fill == 0) begin
      v.front = '1;
      v.back  = '1;
    end else begin
      v.front = slot_mem[head_ptr];
      v.back  = slot_mem[tail];
    end
    v.count = fill;
    v.empty = (fill == 0);
    v.full  = (fill >= lim);  // capacity 0: empty and full together
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional idle cycles (tdata/tuser scrambled while tvalid is low),
  // then hold the request until the transfer happens. tvalid stays high on
  // exit so back-to-back requests do not bounce it within one time step.
  // --------------------------------------------------------------------------
  task automatic issue_request(input req_t req, input logic [VALUE_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= REQ_W'($urandom_range(3));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_views.insert(pending_views.size(), deque_apply(req, word));
  endtask

  // Drop tvalid and wait until every expected result has been collected.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Capacity writes only happen with the block idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_reg = cap;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random backpressure per the current stall percentage.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker: each out_ transfer is compared field by field with the
  // oldest prediction. Only the first few failures are printed.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    deque_view_t exp_v;
    deque_view_t got_v;
    if (rst_n && out_tvalid && out_tready) begin
      got_v.status = status_t'(out_tuser);
      got_v.front  = out_tdata[VALUE_W-1:0];
      got_v.back   = out_tdata[2*VALUE_W-1:VALUE_W];
      got_v.count  = out_tdata[2*VALUE_W +: COUNT_W];
      got_v.empty  = out_tdata[2*VALUE_W+COUNT_W];
      got_v.full   = out_tdata[2*VALUE_W+COUNT_W+1];
      if (pending_views.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORT)
          $display("ERROR: unexpected result transfer, tuser=%0d tdata=%h",
                   out_tuser, out_tdata);
      end else begin
        exp_v = pending_views[0];
        pending_views.delete(0);
        if (got_v.status !== exp_v.status || got_v.front !== exp_v.front ||
            got_v.back !== exp_v.back || got_v.count !== exp_v.count ||
            got_v.empty !== exp_v.empty || got_v.full !== exp_v.full) begin
          fail_count++;
          if (fail_count <= MAX_REPORT) begin
            $display("ERROR: mismatch on %s", exp_v.req.name());
            $display("  exp: st=%0d front=%h back=%h count=%0d empty=%b full=%b",
                     exp_v.status, exp_v.front, exp_v.back, exp_v.count,
                     exp_v.empty, exp_v.full);
            $display("  got: st=%0d front=%h back=%h count=%0d empty=%b full=%b",
                     got_v.status, got_v.front, got_v.back, got_v.count,
                     got_v.empty, got_v.full);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no transfer on either stream ends the run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Pops right after reset: underflow at both ends, -1 end words.
  task automatic test_empty_pops();
    issue_request(REQ_POP_FRONT, 32'h1234_5678);
    issue_request(REQ_POP_BACK, 32'hFFFF_FFFF);
  endtask

  // Value extremes pushed from both ends, then drained past empty.
  task automatic test_value_extremes();
    issue_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    issue_request(REQ_PUSH_FRONT, 32'h8000_0000);
    issue_request(REQ_PUSH_BACK, 32'h0000_0000);
    issue_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    issue_request(REQ_POP_FRONT, 32'h0);
    issue_request(REQ_POP_BACK, 32'h0);
    issue_request(REQ_POP_BACK, 32'h0);
    issue_request(REQ_POP_FRONT, 32'h0);
    issue_request(REQ_POP_FRONT, 32'h0);
  endtask

  // Overflow at a small capacity, then the capacity dropped under the count.
  task automatic test_capacity_edges();
    set_capacity(5'd2);
    issue_request(REQ_PUSH_BACK, 32'hA5A5_0001);
    issue_request(REQ_PUSH_FRONT, 32'h5A5A_0002);
    issue_request(REQ_PUSH_BACK, 32'hDEAD_BEEF);  // refused, full
    set_capacity(5'd1);                            // count 2 > capacity 1
    issue_request(REQ_PUSH_FRONT, 32'h0BAD_F00D);
    issue_request(REQ_POP_FRONT, 32'h0);
    issue_request(REQ_POP_BACK, 32'h0);
  endtask

  // Zero capacity: every push refused, empty and full reported together.
  task automatic test_zero_capacity();
    set_capacity(5'd0);
    issue_request(REQ_PUSH_FRONT, 32'h0000_0001);
    issue_request(REQ_PUSH_BACK, 32'h8000_0001);
    issue_request(REQ_POP_FRONT, 32'h0);
  endtask

  // Random push/pop walk. The push bias shifts every 32 requests so the
  // deque swings between empty and full; now and then the sender waits
  // for the whole pipeline to drain.
  task automatic test_random_traffic(input int n_items, input logic [CAP_W-1:0] cap,
                                     input int idle_pct, input int stall_pct);
    int   push_bias;
    logic is_pop;
    logic at_back;
    push_bias = 50;
    set_capacity(cap);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      if (k % 32 == 0)
        case ($urandom_range(2))
          0:       push_bias = 25;
          1:       push_bias = 50;
          default: push_bias = 80;
        endcase
      if ($urandom_range(63) == 0)
        quiesce();
      is_pop  = ($urandom_range(99) >= push_bias);
      at_back = 1'($urandom_range(1));
      // {pop, back} lines up with the request encoding
      issue_request(req_t'({is_pop, at_back}), $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pops();
    test_value_extremes();
    test_capacity_edges();
    test_zero_capacity();

    test_random_traffic(400, 5'd16, 0, 0);
    test_random_traffic(300, 5'd31, 81, 0);   // above depth: acts as 16
    test_random_traffic(300, 5'd5, 0, 81);
    test_random_traffic(200, 5'd1, 6, 6);
    test_random_traffic(300, 5'd16, 6, 6);

    quiesce();
    if (fail_count == 0 && pending_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> bounded_deque_unit.f
rtl/bdq_pkg.sv
rtl/bdq_mem.sv
rtl/bounded_deque_unit.sv
verif/tb_top.sv
